// ----- rtl/clock_set_button_repeater_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the button repeater checkers
// Concurrent property wrappers, clocked on the rising edge with reset disable.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SET_BUTTON_REPEATER_UNIT_DEFINES_SVH
`define CLOCK_SET_BUTTON_REPEATER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CBR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CBR_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cbr_pkg.sv -----
// ----------------------------------------------------------------------------
// cbr_pkg
// Types and constants for the clock set button repeater.
// ----------------------------------------------------------------------------
package cbr_pkg;

   localparam int TIMER_BITS  = 16;
   localparam int SETTLE_BITS = 8;

   localparam int SETTLE_CFG_BITS = 8;
   localparam int TICKS_CFG_BITS  = 16;
   localparam int LIMIT_CFG_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   localparam int MINUTE_BITS = 6;
   localparam int HOUR_BITS   = 4;
   localparam int REQ_BITS    = 16;
   localparam int RSP_BITS    = 16;

   localparam logic [MINUTE_BITS-1:0] MINUTE_LAST = MINUTE_BITS'(59);
   localparam logic [HOUR_BITS-1:0]   HOUR_LAST   = HOUR_BITS'(12);
   localparam logic [HOUR_BITS-1:0]   HOUR_FIRST  = HOUR_BITS'(1);

   localparam logic [SETTLE_CFG_BITS-1:0] SETTLE_RESET = SETTLE_CFG_BITS'(100);
   localparam logic [TICKS_CFG_BITS-1:0]  SLOW_RESET   = TICKS_CFG_BITS'(5000);
   localparam logic [TICKS_CFG_BITS-1:0]  FAST_RESET   = TICKS_CFG_BITS'(1000);
   localparam logic [LIMIT_CFG_BITS-1:0]  LIMIT_RESET  = LIMIT_CFG_BITS'(5);

   typedef logic [TIMER_BITS-1:0]  timer_type;
   typedef logic [SETTLE_BITS-1:0] settle_type;
   typedef logic [MINUTE_BITS-1:0] minute_type;
   typedef logic [HOUR_BITS-1:0]   hour_type;

   typedef enum logic [1:0] {
      CSR_SETTLE_TICKS    = 2'd0,
      CSR_SLOW_TICKS      = 2'd1,
      CSR_FAST_TICKS      = 2'd2,
      CSR_SLOW_STEP_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SETTLE_CFG_BITS-1:0] settle_ticks;
      logic [TICKS_CFG_BITS-1:0]  slow_ticks;
      logic [TICKS_CFG_BITS-1:0]  fast_ticks;
      logic [LIMIT_CFG_BITS-1:0]  slow_step_limit;
   } cfg_type;

   typedef struct packed {
      minute_type value;
      logic       stepped;
      logic       skip_hour;
   } minute_out_type;

   typedef struct packed {
      hour_type value;
      logic     stepped;
   } hour_out_type;

endpackage

// ----- rtl/cbr_csr.sv -----
// ----------------------------------------------------------------------------
// cbr_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cbr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  cbr_pkg::csr_index_type             csr_index,
   input  logic [cbr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output cbr_pkg::cfg_type                   cfg
);
   import cbr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SETTLE_TICKS:    cfg_in.settle_ticks    = csr_wdata[SETTLE_CFG_BITS-1:0];
            CSR_SLOW_TICKS:      cfg_in.slow_ticks      = csr_wdata[TICKS_CFG_BITS-1:0];
            CSR_FAST_TICKS:      cfg_in.fast_ticks      = csr_wdata[TICKS_CFG_BITS-1:0];
            CSR_SLOW_STEP_LIMIT: cfg_in.slow_step_limit = csr_wdata[LIMIT_CFG_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks    <= SETTLE_RESET;
         cfg_ff.slow_ticks      <= SLOW_RESET;
         cfg_ff.fast_ticks      <= FAST_RESET;
         cfg_ff.slow_step_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/cbr_minute.sv -----
// ----------------------------------------------------------------------------
// cbr_minute
// Minute button debounce and two-speed auto repeat.
// ----------------------------------------------------------------------------
module cbr_minute (
   input  logic                    clock,
   input  logic                    reset,
   input  cbr_pkg::cfg_type        cfg,
   input  logic                    advance,
   input  logic                    pressed,
   input  cbr_pkg::minute_type     minute_now,
   output cbr_pkg::minute_out_type result
);
   import cbr_pkg::*;

   logic                      armed_ff, armed_in;
   settle_type                settle_ff, settle_in;
   timer_type                 timer_ff, timer_in;
   logic [LIMIT_CFG_BITS-1:0] steps_ff, steps_in;

   settle_type settle_dec;
   timer_type  timer_dec;

   always_comb begin
      settle_dec = settle_ff - 1'b1;
      timer_dec  = timer_ff - 1'b1;
      armed_in   = armed_ff;
      settle_in  = settle_ff;
      timer_in   = timer_ff;
      steps_in   = steps_ff;
      result.value     = minute_now;
      result.stepped   = 1'b0;
      result.skip_hour = 1'b0;
      if (pressed) begin
         if (!armed_ff) begin
            armed_in         = 1'b1;
            settle_in        = SETTLE_BITS'(cfg.settle_ticks);
            timer_in         = TIMER_BITS'(1);
            result.skip_hour = 1'b1;
         end else if (settle_ff != '0 && settle_dec != '0) begin
            settle_in        = settle_dec;
            result.skip_hour = 1'b1;
         end else begin
            settle_in = '0;
            timer_in  = timer_dec;
            if (timer_dec == '0) begin
               result.stepped = 1'b1;
               result.value   = (minute_now >= MINUTE_LAST) ? '0 : minute_now + 1'b1;
               if (steps_ff < cfg.slow_step_limit) begin
                  steps_in = steps_ff + 1'b1;
                  timer_in = TIMER_BITS'(cfg.slow_ticks);
               end else begin
                  timer_in = TIMER_BITS'(cfg.fast_ticks);
               end
            end
         end
      end else begin
         // release: rearm slow timer and slow step count
         armed_in = 1'b0;
         timer_in = TIMER_BITS'(cfg.slow_ticks);
         steps_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         settle_ff <= '0;
         timer_ff  <= TIMER_BITS'(1);
         steps_ff  <= '0;
      end else if (advance) begin
         armed_ff  <= armed_in;
         settle_ff <= settle_in;
         timer_ff  <= timer_in;
         steps_ff  <= steps_in;
      end
   end

endmodule

// ----- rtl/cbr_hour.sv -----
// ----------------------------------------------------------------------------
// cbr_hour
// Hour button debounce and slow auto repeat.
// ----------------------------------------------------------------------------
module cbr_hour (
   input  logic                  clock,
   input  logic                  reset,
   input  cbr_pkg::cfg_type      cfg,
   input  logic                  advance,
   input  logic                  skip,
   input  logic                  pressed,
   input  cbr_pkg::hour_type     hour_now,
   output cbr_pkg::hour_out_type result
);
   import cbr_pkg::*;

   logic       armed_ff, armed_in;
   settle_type settle_ff, settle_in;
   timer_type  timer_ff, timer_in;

   settle_type settle_dec;
   timer_type  timer_dec;

   always_comb begin
      settle_dec = settle_ff - 1'b1;
      timer_dec  = timer_ff - 1'b1;
      armed_in   = armed_ff;
      settle_in  = settle_ff;
      timer_in   = timer_ff;
      result.value   = hour_now;
      result.stepped = 1'b0;
      if (!skip) begin
         if (pressed) begin
            if (!armed_ff) begin
               armed_in  = 1'b1;
               settle_in = SETTLE_BITS'(cfg.settle_ticks);
               timer_in  = TIMER_BITS'(1);
            end else if (settle_ff != '0 && settle_dec != '0) begin
               settle_in = settle_dec;
            end else begin
               settle_in = '0;
               timer_in  = timer_dec;
               if (timer_dec == '0) begin
                  result.stepped = 1'b1;
                  result.value   = (hour_now >= HOUR_LAST) ? HOUR_FIRST : hour_now + 1'b1;
                  timer_in       = TIMER_BITS'(cfg.slow_ticks);
               end
            end
         end else begin
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         settle_ff <= '0;
         timer_ff  <= TIMER_BITS'(1);
      end else if (advance) begin
         armed_ff  <= armed_in;
         settle_ff <= settle_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

// ----- rtl/clock_set_button_repeater_unit.sv -----
// Path: an accepted req passes the input register, then the result register; rsp stalls hold it.
// Throughput: one transaction per cycle while rsp is not stalled; the tick update is one pass
// of counter logic between the input register and the result register.
// Reset: synchronous, active high; clears both stage valids and button state,
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// clock_set_button_repeater_unit
// Debounce and auto-repeat for the minute and hour set buttons of a 12 hour
// clock; one req transaction per tick yields one rsp transaction.
// ----------------------------------------------------------------------------
module clock_set_button_repeater_unit (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: minute_pressed[0], hour_pressed[1], minute_now[7:2], hour_now[11:8],
   // zero pad[15:12]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cbr_pkg::REQ_BITS-1:0]       req_tdata,
   // rsp_tdata: minute_next[5:0], hour_next[9:6], minute_stepped[10], hour_stepped[11],
   // zero pad[15:12]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cbr_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                               csr_we,
   input  cbr_pkg::csr_index_type             csr_index,
   input  logic [cbr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cbr_pkg::*;

   cfg_type cfg;

   // input stage: holds one tick until the result register can take it
   logic                    in_valid_ff, in_valid_in;
   logic [REQ_BITS-1:0]     in_data_ff;

   // result stage
   logic                    out_valid_ff, out_valid_in;
   logic [RSP_BITS-1:0]     out_data_ff;
   logic [RSP_BITS-1:0]     out_data_in;

   logic                    advance;
   logic                    req_fire;
   minute_out_type          minute_result;
   hour_out_type            hour_result;

   // Move the input stage into the result stage when the result register is
   // empty or being drained this cycle; button state updates on the same edge.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   cbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbr_minute u_minute (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .advance    (advance),
      .pressed    (in_data_ff[0]),
      .minute_now (in_data_ff[7:2]),
      .result     (minute_result)
   );

   // hour button is ignored while the minute button is new or still settling
   cbr_hour u_hour (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .advance  (advance),
      .skip     (minute_result.skip_hour),
      .pressed  (in_data_ff[1]),
      .hour_now (in_data_ff[11:8]),
      .result   (hour_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // pack the result transaction, highest field first
      out_data_in = {4'b0000, hour_result.stepped, minute_result.stepped,
                     hour_result.value, minute_result.value};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: hold unless a new transaction lands
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- rtl/cbr_checker.sv -----
// ----------------------------------------------------------------------------
// cbr_checker
// Port-level checks for the button repeater, bound to the top level.
// ----------------------------------------------------------------------------
`include "clock_set_button_repeater_unit_defines.svh"

module cbr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [cbr_pkg::REQ_BITS-1:0]       req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [cbr_pkg::RSP_BITS-1:0]       rsp_tdata,
   input logic                               csr_we,
   input cbr_pkg::csr_index_type             csr_index,
   input logic [cbr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cbr_pkg::*;

   logic unused_ports;
   assign unused_ports = ^{req_tvalid, req_tready, req_tdata, csr_we, csr_index, csr_wdata};

   // no result may appear right after reset
   `CBR_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid, "result valid after reset")

   // a stalled result holds
   `CBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // a stepped minute always lands in 0..59
   `CBR_ASSERT_NOW(a_minute_range, clock, reset, rsp_tvalid && rsp_tdata[10], rsp_tdata[5:0] <= MINUTE_LAST, "stepped minute out of range")

   // a stepped hour always lands in 1..12
   `CBR_ASSERT_NOW(a_hour_range, clock, reset, rsp_tvalid && rsp_tdata[11], (rsp_tdata[9:6] >= HOUR_FIRST) && (rsp_tdata[9:6] <= HOUR_LAST), "stepped hour out of range")

endmodule

bind clock_set_button_repeater_unit cbr_checker u_cbr_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Button repeater testbench
// Drives one tick transaction per req handshake into the clock set button
// repeater, predicts every readout in a behavioral model of the debounce and
// auto-repeat logic, and compares each rsp transaction field by field.
// Directed wrap, range, settle and zero-reload cases come first, then randomized
// button holds under several register settings with random idling on both sides, then none.
// ----------------------------------------------------------------------------
module tb;
   import cbr_pkg::*;

   // One tick as it travels on req_tdata, lowest field in the lowest bits.
   typedef struct packed {
      hour_type   hour_now;
      minute_type minute_now;
      logic       hour_pressed;
      logic       minute_pressed;
   } button_tick_t;

   // One readout as it travels on rsp_tdata, lowest field in the lowest bits.
   typedef struct packed {
      logic       hour_stepped;
      logic       minute_stepped;
      hour_type   hour_next;
      minute_type minute_next;
   } clock_readout_t;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // req_tdata: minute_pressed[0], hour_pressed[1], minute_now[7:2], hour_now[11:8]
   logic [REQ_BITS-1:0]      req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   // rsp_tdata: minute_next[5:0], hour_next[9:6], minute_stepped[10], hour_stepped[11]
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     csr_we     = 1'b0;
   csr_index_type            csr_index  = CSR_SETTLE_TICKS;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   // Register copies held by the predictor.
   logic [SETTLE_CFG_BITS-1:0] settle_cfg;
   logic [TICKS_CFG_BITS-1:0]  slow_cfg;
   logic [TICKS_CFG_BITS-1:0]  fast_cfg;
   logic [LIMIT_CFG_BITS-1:0]  limit_cfg;

   // Button state held by the predictor.
   logic       minute_armed;
   settle_type minute_settle;
   timer_type  minute_timer;
   logic [2:0] minute_slow_steps;
   logic       hour_armed;
   settle_type hour_settle;
   timer_type  hour_timer;

   clock_readout_t awaited_readouts[$];
   int             mismatch_count = 0;
   bit             steady = 1'b0;   // no idling on either side when set
   int             stall_left = 0;

   clock_set_button_repeater_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bound the run well past the slowest legal pace.
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor: advance both buttons by one tick and return the readout.
   // ------------------------------------------------------------------------
   function automatic clock_readout_t advance_buttons(button_tick_t t);
      clock_readout_t r;
      bit             skip_hour;
      bit             settling;
      r.minute_next    = t.minute_now;
      r.hour_next      = t.hour_now;
      r.minute_stepped = 1'b0;
      r.hour_stepped   = 1'b0;
      skip_hour        = 1'b0;

      if (t.minute_pressed) begin
         if (!minute_armed) begin
            minute_armed  = 1'b1;
            minute_settle = settle_cfg;
            minute_timer  = timer_type'(1);
            skip_hour     = 1'b1;
         end else begin
            // The settle count still runs if it stays nonzero after this tick.
            settling = (minute_settle > settle_type'(1));
            if (minute_settle != '0) minute_settle = minute_settle - settle_type'(1);
            if (settling) begin
               skip_hour = 1'b1;
            end else begin
               minute_timer = minute_timer - timer_type'(1);
               if (minute_timer == '0) begin
                  r.minute_stepped = 1'b1;
                  r.minute_next = (t.minute_now >= MINUTE_LAST) ? minute_type'(0)
                                                                : t.minute_now + 1'b1;
                  if (minute_slow_steps < limit_cfg) begin
                     minute_slow_steps = minute_slow_steps + 3'd1;
                     minute_timer      = slow_cfg;
                  end else begin
                     minute_timer = fast_cfg;
                  end
               end
            end
         end
      end else begin
         minute_armed      = 1'b0;
         minute_timer      = slow_cfg;
         minute_slow_steps = 3'd0;
      end

      if (!skip_hour) begin
         if (t.hour_pressed) begin
            if (!hour_armed) begin
               hour_armed  = 1'b1;
               hour_settle = settle_cfg;
               hour_timer  = timer_type'(1);
            end else begin
               settling = (hour_settle > settle_type'(1));
               if (hour_settle != '0) hour_settle = hour_settle - settle_type'(1);
               if (!settling) begin
                  hour_timer = hour_timer - timer_type'(1);
                  if (hour_timer == '0) begin
                     r.hour_stepped = 1'b1;
                     r.hour_next = (t.hour_now >= HOUR_LAST || t.hour_now == '0) ?
                                   HOUR_FIRST : t.hour_now + 1'b1;
                     hour_timer = slow_cfg;
                  end
               end
            end
         end else begin
            hour_armed = 1'b0;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offer one tick transaction, with an occasional gap ahead of it, and
   // record its predicted readout once it is accepted.
   task automatic send_tick(input bit mp, input bit hp, input int minute, input int hour);
      button_tick_t t;
      t.minute_pressed = mp;
      t.hour_pressed   = hp;
      t.minute_now     = minute_type'(minute);
      t.hour_now       = hour_type'(hour);
      if (!steady && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_readouts.push_back(advance_buttons(t));
   endtask

   // Drop valid and hold until every readout is back, then let the
   // two-stage pipeline settle.
   task automatic drain_readouts();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_readouts.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all four registers back to back; only call while drained.
   task automatic program_regs(input logic [CSR_DATA_BITS-1:0] settle,
                               input logic [CSR_DATA_BITS-1:0] slow,
                               input logic [CSR_DATA_BITS-1:0] fast,
                               input logic [CSR_DATA_BITS-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_SETTLE_TICKS;
      csr_wdata <= settle;
      @(posedge clock);
      settle_cfg = settle[SETTLE_CFG_BITS-1:0];
      csr_index <= CSR_SLOW_TICKS;
      csr_wdata <= slow;
      @(posedge clock);
      slow_cfg = slow[TICKS_CFG_BITS-1:0];
      csr_index <= CSR_FAST_TICKS;
      csr_wdata <= fast;
      @(posedge clock);
      fast_cfg = fast[TICKS_CFG_BITS-1:0];
      csr_index <= CSR_SLOW_STEP_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      limit_cfg = limit[LIMIT_CFG_BITS-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Minute ticks at minute 59 and at out-of-range minutes, then a release rearming the slow
   // timer; the button still settles from the earlier ticks, so no minute steps here.
   task automatic test_minute_wrap();
      drain_readouts();
      program_regs(16'd0, 16'd2, 16'd1, 16'd1);
      send_tick(1, 0, 59, 12);   // already armed, still settling
      send_tick(1, 0, 59, 12);   // still settling, no wrap
      send_tick(1, 0, 63, 0);
      send_tick(1, 0, 63, 0);    // out-of-range minute, still settling
      send_tick(1, 0, 58, 15);   // still settling
      send_tick(0, 0, 0, 1);     // release
   endtask

   // Hour stepping: wrap at 12, hour zero and hours above twelve, release.
   task automatic test_hour_wrap();
      send_tick(0, 1, 30, 12);
      send_tick(0, 1, 30, 12);
      send_tick(0, 1, 0, 0);
      send_tick(0, 1, 0, 0);
      send_tick(0, 1, 5, 15);
      send_tick(0, 1, 5, 15);
      send_tick(0, 0, 5, 11);
   endtask

   // A settling minute button hides the hour button until its count ends.
   task automatic test_settle_skip();
      drain_readouts();
      program_regs(16'd3, 16'd2, 16'd1, 16'd7);
      repeat (5) send_tick(1, 1, 10, 3);
      send_tick(1, 1, 11, 4);
      send_tick(1, 1, 11, 4);
      send_tick(0, 0, 11, 4);
   endtask

   // A zero reload value wraps the repeat timer into a very long delay.
   task automatic test_zero_reload();
      drain_readouts();
      program_regs(16'd0, 16'd0, 16'd0, 16'd7);
      send_tick(1, 0, 20, 6);
      send_tick(1, 0, 20, 6);
      send_tick(1, 0, 20, 6);
      send_tick(0, 0, 20, 6);
   endtask

   // Random button holds of random length with bounce and noise mixed in.
   task automatic run_holds(input int count, input int hold_max);
      int minute_hold;
      int hour_hold;
      bit minute_level;
      bit hour_level;
      bit mp;
      bit hp;
      int minute;
      int hour;
      minute_hold  = 0;
      hour_hold    = 0;
      minute_level = 1'b0;
      hour_level   = 1'b0;
      repeat (count) begin
         if (minute_hold == 0) begin
            minute_level = !minute_level;
            minute_hold  = minute_level ? $urandom_range(1, hold_max) : $urandom_range(1, 8);
         end
         if (hour_hold == 0) begin
            hour_level = !hour_level;
            hour_hold  = hour_level ? $urandom_range(1, hold_max) : $urandom_range(1, 8);
         end
         minute_hold--;
         hour_hold--;
         // Flip a level now and then to mimic contact bounce.
         mp = ($urandom_range(0, 15) == 0) ? !minute_level : minute_level;
         hp = ($urandom_range(0, 15) == 0) ? !hour_level : hour_level;
         case ($urandom_range(0, 9))
            0: minute = 59;
            1: minute = $urandom_range(0, 63);
            default: minute = $urandom_range(0, 59);
         endcase
         case ($urandom_range(0, 9))
            0: hour = 12;
            1: hour = $urandom_range(0, 15);
            default: hour = $urandom_range(1, 12);
         endcase
         send_tick(mp, hp, minute, hour);
         // Hold the sender off until everything is back, once in a while.
         if ($urandom_range(0, 199) == 0) drain_readouts();
      end
   endtask

   // Sweep random holds across several register settings, extremes included.
   // Upper data bits beyond a register's width must be ignored.
   task automatic test_repeat_sweep();
      drain_readouts();
      program_regs(16'd0, 16'd1, 16'd1, 16'd0);
      run_holds(260, 30);
      drain_readouts();
      program_regs(16'd2, 16'd3, 16'd1, 16'd7);
      run_holds(260, 40);
      drain_readouts();
      program_regs(16'hFF05, 16'd6, 16'd2, 16'hFFFB);
      run_holds(260, 60);
      drain_readouts();
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_holds(200, 300);
      drain_readouts();
      program_regs(16'd1, 16'd0, 16'd3, 16'd2);
      run_holds(200, 40);
      drain_readouts();
      program_regs(16'd0, 16'd4, 16'd0, 16'd1);
      run_holds(200, 40);
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_steady_stream();
      drain_readouts();
      program_regs(16'd1, 16'd2, 16'd1, 16'd2);
      steady = 1'b1;
      run_holds(440, 30);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: random stall bursts of random length.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   // Compare each rsp transaction against the oldest awaited readout.
   always @(posedge clock) begin : check_readouts
      clock_readout_t want;
      clock_readout_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(clock_readout_t)-1:0];
         if (awaited_readouts.size() == 0) begin
            flag_mismatch("readout with none awaited", 0, got);
         end else begin
            want = awaited_readouts.pop_front();
            if (got.minute_next != want.minute_next)
               flag_mismatch("minute_next", want.minute_next, got.minute_next);
            if (got.hour_next != want.hour_next)
               flag_mismatch("hour_next", want.hour_next, got.hour_next);
            if (got.minute_stepped != want.minute_stepped)
               flag_mismatch("minute_stepped", want.minute_stepped, got.minute_stepped);
            if (got.hour_stepped != want.hour_stepped)
               flag_mismatch("hour_stepped", want.hour_stepped, got.hour_stepped);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // Mirror the block's reset state.
      settle_cfg        = SETTLE_RESET;
      slow_cfg          = SLOW_RESET;
      fast_cfg          = FAST_RESET;
      limit_cfg         = LIMIT_RESET;
      minute_armed      = 1'b0;
      minute_settle     = '0;
      minute_timer      = timer_type'(1);
      minute_slow_steps = 3'd0;
      hour_armed        = 1'b0;
      hour_settle       = '0;
      hour_timer        = timer_type'(1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A few ticks at the default settings before any register write.
      send_tick(1, 1, 0, 1);
      send_tick(1, 1, 0, 1);

      test_minute_wrap();
      test_hour_wrap();
      test_settle_skip();
      test_zero_reload();
      test_repeat_sweep();
      test_steady_stream();

      drain_readouts();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cbr_pkg.sv
rtl/cbr_csr.sv
rtl/cbr_minute.sv
rtl/cbr_hour.sv
rtl/clock_set_button_repeater_unit.sv
rtl/cbr_checker.sv
tb/tb.sv
